### rtl/list_sorter_asc_desc_macros.svh
// Assertion macros shared by the list sorter checker.
// Depends on nothing; included by the checker file only.
`ifndef LIST_SORTER_ASC_DESC_MACROS_SVH
`define LIST_SORTER_ASC_DESC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lsad_pkg.sv
// Shared types for the list sorter: element type and the command and
// status groups between controller and datapath. Depends on nothing.
package lsad_pkg;

	// One list element, two's complement.
	typedef logic signed [31:0] value_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;     // place the accepted element into the cell chain
		logic pop;        // shift the head element out of the chain
		logic cfg_write;  // load the sort order register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic holding;    // the head cell holds an element
		logic last_one;   // the head cell holds the only remaining element
	} status_t;

endpackage

### rtl/lsad_datapath.sv
// Cell chain datapath: sorted insertion of each element as it arrives,
// shift-out from the head cell, overflow flag and sort order register.
// Depends on lsad_pkg.
module lsad_datapath #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lsad_pkg::cmd_t   cmd,
	input  lsad_pkg::value_t element_value,
	input  logic             sort_ascending,
	output lsad_pkg::value_t sorted_value,
	output logic             overflow,
	output lsad_pkg::status_t status
);
	import lsad_pkg::*;

	// Cell contents and occupancy; occupancy is always a prefix of the chain.
	value_t                    cell_q [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]   valid_q;
	logic                      overflow_q;
	logic                      ascending_q;

	// A cell is at or past the insertion point when it is empty or its
	// element must come after the new one in the chosen order.
	logic [MAX_ELEMENTS-1:0]   after_new;
	logic                      full;
	logic                      do_insert;

	assign full      = valid_q[MAX_ELEMENTS-1];
	assign do_insert = cmd.insert && !full;

	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if (!valid_q[i]) begin
				after_new[i] = 1'b1;
			end else if (ascending_q) begin
				after_new[i] = cell_q[i] > element_value;
			end else begin
				after_new[i] = cell_q[i] < element_value;
			end
		end
	end

	// Head cell: takes the new element, or the neighbor on a pop.
	always_ff @(posedge clk) begin
		if (do_insert && after_new[0]) begin
			cell_q[0] <= element_value;
		end else if (cmd.pop) begin
			cell_q[0] <= cell_q[1];
		end
	end

	// Remaining cells: shift right past the insertion point, left on a pop.
	for (genvar g = 1; g < MAX_ELEMENTS; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert && after_new[g]) begin
				if (after_new[g-1]) begin
					cell_q[g] <= cell_q[g-1];
				end else begin
					cell_q[g] <= element_value;
				end
			end else if (cmd.pop) begin
				if (g < MAX_ELEMENTS - 1) begin
					cell_q[g] <= cell_q[(g + 1) % MAX_ELEMENTS];
				end
			end
		end
	end

	// Occupancy, overflow flag and sort order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			overflow_q  <= 1'b0;
			ascending_q <= 1'b1;
		end else begin
			if (do_insert) begin
				valid_q <= {valid_q[MAX_ELEMENTS-2:0], 1'b1};
			end else if (cmd.pop) begin
				valid_q <= {1'b0, valid_q[MAX_ELEMENTS-1:1]};
			end
			if (cmd.insert && full) begin
				overflow_q <= 1'b1;
			end else if (cmd.pop && !valid_q[1]) begin
				overflow_q <= 1'b0;
			end
			if (cmd.cfg_write) begin
				ascending_q <= sort_ascending;
			end
		end
	end

	assign sorted_value    = cell_q[0];
	assign overflow        = overflow_q;
	assign status.holding  = valid_q[0];
	assign status.last_one = valid_q[0] && !valid_q[1];

endmodule

### rtl/lsad_ctrl.sv
// Controller for the list sorter: load and drain phases, handshakes
// and the command group for the datapath. Depends on lsad_pkg.
module lsad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              last_in,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  lsad_pkg::status_t status,
	output lsad_pkg::cmd_t    cmd
);
	import lsad_pkg::*;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic in_take;
	logic out_take;

	// Inputs flow while loading; results flow while draining.
	// The sort order only changes while the chain is empty, so every
	// element of a list is placed under the same order.
	assign in_stall  = (state_q == ST_DRAIN);
	assign out_valid = (state_q == ST_DRAIN) && status.holding;
	assign cfg_ready = (state_q == ST_LOAD) && !status.holding;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;

	assign cmd.insert    = in_take;
	assign cmd.pop       = out_take;
	assign cmd.cfg_write = cfg_valid && cfg_ready;

	// Phase sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_take && last_in) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_take && status.last_one) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

### rtl/list_sorter_asc_desc.sv
// Channel  | handshake                 | payload
// input    | in_valid / in_stall       | element_value, last_in
// result   | out_valid / out_stall     | sorted_value, last_out, overflow
// config   | cfg_valid / cfg_ready     | sort_ascending
//
// While loading, each cell of the chain compares in parallel and the new
// element drops into its sorted place on arrival.
// The transaction that closes a list starts the drain; the stored elements
// then leave one result per cycle while out_stall is low.
// Input is stalled during the drain. Reset empties the chain at once.
// The order register accepts a write only while the chain is empty.
// Top level of the list sorter. Depends on lsad_pkg, lsad_ctrl, lsad_datapath.
module list_sorter_asc_desc #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lsad_pkg::value_t element_value,
	input  logic             last_in,
	output logic             out_valid,
	input  logic             out_stall,
	output lsad_pkg::value_t sorted_value,
	output logic             last_out,
	output logic             overflow,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             sort_ascending
);
	import lsad_pkg::*;

	cmd_t    cmd;
	status_t status;

	lsad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lsad_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.element_value  (element_value),
		.sort_ascending (sort_ascending),
		.sorted_value   (sorted_value),
		.overflow       (overflow),
		.status         (status)
	);

	// The head element is final when no other element remains behind it.
	assign last_out = status.last_one;

endmodule

### rtl/lsad_checker.sv
// Port-level checker for the list sorter, bound to the top level.
// Depends on list_sorter_asc_desc_macros.svh and list_sorter_asc_desc.
`include "list_sorter_asc_desc_macros.svh"

module lsad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] sorted_value,
	input logic        last_out,
	input logic        overflow
);

	// Input is held off exactly while results are pending.
	`LSAD_ASSERT_NOW(a_stall_matches_drain, clk, arst_n, 1'b1, out_valid == in_stall, "input stall differs from drain phase")

	// A closing transaction always yields at least one result next cycle.
	`LSAD_ASSERT_NEXT(a_close_starts_drain, clk, arst_n, in_valid && !in_stall && last_in, out_valid, "no result after closing transaction")

	// Taking the final result ends the drain.
	`LSAD_ASSERT_NEXT(a_last_ends_drain, clk, arst_n, out_valid && !out_stall && last_out, !out_valid, "results continue after final result")

	// The overflow flag is the same for every result of one list.
	`LSAD_ASSERT_NOW(a_overflow_steady, clk, arst_n, out_valid && $past(out_valid), $stable(overflow), "overflow flag changed within a list")

	// A stalled result holds its value.
	`LSAD_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(sorted_value), "stalled result changed")

endmodule

bind list_sorter_asc_desc lsad_checker u_lsad_checker (.*);
